FILE: design/video_thumbnail_decimator_yuv_rgb_macros.svh
// Assertion macros for the thumbnail decimator.
// Depends on nothing; included by the files that carry assertions.
`ifndef VIDEO_THUMBNAIL_DECIMATOR_YUV_RGB_MACROS_SVH
`define VIDEO_THUMBNAIL_DECIMATOR_YUV_RGB_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define VTD_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");
// Next-cycle implication, checked out of reset.
`define VTD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define VTD_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define VTD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: design/vtd_pkg.sv
// Package for the thumbnail decimator: payload structs, register indexes,
// sampling constants and small helper functions. No dependencies.
package vtd_pkg;

   // Register indexes of the configuration port
   localparam int unsigned CsrIndexWidth = 4;
   localparam logic [CsrIndexWidth-1:0] CSR_MODE_TALL = 4'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_GRAY_MODE = 4'd1;
   localparam int unsigned CsrDataWidth = 8;

   // Raster geometry
   localparam logic [3:0] LAST_GROUP  = 4'd15;   // 16 groups of 22 columns
   localparam logic [4:0] LAST_OFFSET = 5'd21;
   localparam logic [5:0] THUMB_ROWS  = 6'd56;
   localparam logic [5:0] LAST_ROW    = 6'd55;
   localparam logic [2:0] LAST_PHASE  = 3'd6;

   typedef struct packed {
      logic [7:0] luma;
      logic [7:0] chroma_blue;
      logic [7:0] chroma_red;
      logic       frame_start;
   } req_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [5:0] thumb_col;
      logic [5:0] thumb_row;
      logic       thumb_last;
   } rsp_type;

   // Column picked inside a 22-column group: hit flag plus slot 0..3
   typedef struct packed {
      logic       hit;
      logic [1:0] slot;
   } col_pick_type;

   function automatic col_pick_type column_slot(input logic [4:0] off);
      col_pick_type p;
      p = '{hit: 1'b0, slot: 2'd0};
      unique case (off)
         5'd0:    p = '{hit: 1'b1, slot: 2'd0};
         5'd6:    p = '{hit: 1'b1, slot: 2'd1};
         5'd11:   p = '{hit: 1'b1, slot: 2'd2};
         5'd17:   p = '{hit: 1'b1, slot: 2'd3};
         default: p = '{hit: 1'b0, slot: 2'd0};
      endcase
      return p;
   endfunction

   // Source-line step for the given phase of the seven-row cycle
   function automatic logic [2:0] line_step(input logic tall, input logic [2:0] phase);
      logic [2:0] s;
      if (tall) begin
         s = (phase >= 3'd6) ? 3'd6 : 3'd5;
      end else begin
         s = (phase < 3'd2) ? 3'd5 : 3'd4;
      end
      return s;
   endfunction

   // Saturate a signed sum in -128..382 to a byte
   function automatic logic [7:0] clamp_byte(input logic signed [9:0] v);
      logic [7:0] c;
      if (v[9]) begin
         c = 8'd0;
      end else if (v[8]) begin
         c = 8'd255;
      end else begin
         c = v[7:0];
      end
      return c;
   endfunction

endpackage

FILE: design/video_thumbnail_decimator_yuv_rgb.sv
// Thumbnail decimator top level; depends on vtd_pkg and the assertion macros header.
// A picked source pixel is registered in stage 1 and then in the stage 2 output register.
// Throughput: one source pixel per cycle, unpicked pixels give no result; stage 1
// counts and selects, stage 2 converts color; a stalled output stalls both stages.
// Reset (synchronous, active high) clears counters and valid bits; the reset
// state acts as the start of a frame.
`include "video_thumbnail_decimator_yuv_rgb_macros.svh"

module video_thumbnail_decimator_yuv_rgb (
   input  logic                                 clock,
   input  logic                                 reset,
   // source pixel channel
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  vtd_pkg::req_type                     req_data,
   // thumbnail pixel channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output vtd_pkg::rsp_type                     rsp_data,
   // register write channel
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [vtd_pkg::CsrIndexWidth-1:0]    csr_index,
   input  logic [vtd_pkg::CsrDataWidth-1:0]     csr_wdata
);
   import vtd_pkg::*;

   // Registers
   logic       mode_tall_ff, gray_mode_ff;
   logic [3:0] group_ff,  group_in;
   logic [4:0] offset_ff, offset_in;
   logic [8:0] line_ff,   line_in;
   logic [8:0] next_line_ff, next_line_in;
   logic [2:0] phase_ff,  phase_in;
   logic [5:0] out_line_ff, out_line_in;

   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_luma_ff, s1_cb_ff, s1_cr_ff;
   logic [5:0] s1_col_ff, s1_col_in;
   logic [5:0] s1_row_ff, s1_row_in;
   logic       s1_last_ff, s1_last_in;

   logic       rsp_valid_ff;
   rsp_type    rsp_data_ff, rsp_data_in;

   // Handshake: both stages move together when the output can take a result
   logic advance, accept;
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && advance;
   assign req_ready = advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign csr_ready = 1'b1;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_tall_ff <= 1'b0;
         gray_mode_ff <= 1'b0;
      end else if (csr_valid) begin
         if (csr_index == CSR_MODE_TALL) begin
            mode_tall_ff <= csr_wdata[0];
         end else if (csr_index == CSR_GRAY_MODE) begin
            gray_mode_ff <= csr_wdata[0];
         end
      end
   end

   // Stage 1: frame counters and pixel selection
   logic [3:0]   grp_e;
   logic [4:0]   off_e;
   logic [8:0]   line_e, next_e;
   logic [2:0]   phase_e;
   logic [5:0]   oline_e;
   logic         on_row, line_end;
   col_pick_type pick;

   always_comb begin
      // frame_start clears the counters before this pixel is handled
      grp_e   = req_data.frame_start ? '0 : group_ff;
      off_e   = req_data.frame_start ? '0 : offset_ff;
      line_e  = req_data.frame_start ? '0 : line_ff;
      next_e  = req_data.frame_start ? '0 : next_line_ff;
      phase_e = req_data.frame_start ? '0 : phase_ff;
      oline_e = req_data.frame_start ? '0 : out_line_ff;

      on_row   = (oline_e < THUMB_ROWS) && (line_e == next_e);
      pick     = column_slot(off_e);
      line_end = (grp_e == LAST_GROUP) && (off_e == LAST_OFFSET);

      s1_valid_in = accept && on_row && pick.hit;
      s1_col_in   = {grp_e, pick.slot};
      s1_row_in   = LAST_ROW - oline_e;
      s1_last_in  = (oline_e == LAST_ROW) && (s1_col_in == 6'd63);

      // column position within the line
      if (off_e == LAST_OFFSET) begin
         offset_in = '0;
         group_in  = grp_e + 4'd1;   // wraps to 0 after the last group
      end else begin
         offset_in = off_e + 5'd1;
         group_in  = grp_e;
      end

      // line bookkeeping at the end of each source line
      line_in      = line_e;
      next_line_in = next_e;
      phase_in     = phase_e;
      out_line_in  = oline_e;
      if (line_end) begin
         line_in = line_e + 9'd1;
         if (on_row) begin
            next_line_in = next_e + {6'd0, line_step(mode_tall_ff, phase_e)};
            out_line_in  = oline_e + 6'd1;
            phase_in     = (phase_e == LAST_PHASE) ? 3'd0 : phase_e + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         group_ff     <= '0;
         offset_ff    <= '0;
         line_ff      <= '0;
         next_line_ff <= '0;
         phase_ff     <= '0;
         out_line_ff  <= '0;
      end else if (accept) begin
         group_ff     <= group_in;
         offset_ff    <= offset_in;
         line_ff      <= line_in;
         next_line_ff <= next_line_in;
         phase_ff     <= phase_in;
         out_line_ff  <= out_line_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_luma_ff <= req_data.luma;
         s1_cb_ff   <= req_data.chroma_blue;
         s1_cr_ff   <= req_data.chroma_red;
         s1_col_ff  <= s1_col_in;
         s1_row_ff  <= s1_row_in;
         s1_last_ff <= s1_last_in;
      end
   end

   // Stage 2: simplified YCbCr to RGB with saturation
   logic signed [9:0] y_s, cb_s, cr_s, cr_half, r_sum, g_sum, b_sum;

   always_comb begin
      y_s     = $signed({2'b00, s1_luma_ff});
      cb_s    = $signed({2'b00, s1_cb_ff}) - 10'sd128;
      cr_s    = $signed({2'b00, s1_cr_ff}) - 10'sd128;
      // halve toward zero: bias negative values by one before the shift
      cr_half = (cr_s + $signed({9'd0, cr_s[9]})) >>> 1;
      r_sum   = y_s + cr_s;
      g_sum   = y_s - cr_half;
      b_sum   = y_s + cb_s;

      rsp_data_in.thumb_col  = s1_col_ff;
      rsp_data_in.thumb_row  = s1_row_ff;
      rsp_data_in.thumb_last = s1_last_ff;
      if (gray_mode_ff) begin
         rsp_data_in.red   = s1_luma_ff;
         rsp_data_in.green = s1_luma_ff;
         rsp_data_in.blue  = s1_luma_ff;
      end else begin
         rsp_data_in.red   = clamp_byte(r_sum);
         rsp_data_in.green = clamp_byte(g_sum);
         rsp_data_in.blue  = clamp_byte(b_sum);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // Checks
   `VTD_ASSERT_IMPLY(a_last_is_corner, clock, reset,
      s1_valid_ff && s1_last_ff, (s1_col_ff == 6'd63) && (s1_row_ff == 6'd0))
   `VTD_ASSERT_NEXT(a_done_gives_nothing, clock, reset,
      accept && !req_data.frame_start && (out_line_ff == THUMB_ROWS), !s1_valid_ff)
   `VTD_ASSERT_NEXT(a_line_wrap, clock, reset,
      accept && line_end, (group_ff == 4'd0) && (offset_ff == 5'd0))
   `VTD_ASSERT_IMPLY(a_gray_equal, clock, reset,
      rsp_valid_ff && gray_mode_ff,
      (rsp_data_ff.red == rsp_data_ff.green) && (rsp_data_ff.green == rsp_data_ff.blue))

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the YCbCr raster to RGB thumbnail decimator.
// Depends on vtd_pkg and the video_thumbnail_decimator_yuv_rgb design files.
`timescale 1ns / 100ps

module tb_top;
   import vtd_pkg::*;

   localparam int HALF_PERIOD  = 10;
   localparam int RESET_CYCLES = 6;
   localparam int DRAIN_CYCLES = 8;
   localparam int TIMEOUT_NS   = 5_000_000;
   localparam int MAX_REPORTS  = 50;

   // Source raster and thumbnail geometry
   localparam int LINE_PIXELS  = 352;
   localparam int GROUP_SPAN   = 22;
   localparam int CYCLE_ROWS   = 7;
   localparam int THUMB_HEIGHT = 56;
   localparam int LAST_COL     = 63;
   localparam int CHROMA_ZERO  = 128;

   // Register indexes outside the register list; writes to them are dropped
   localparam logic [3:0] CSR_SPARE_LO = 4'd2;
   localparam logic [3:0] CSR_SPARE_HI = 4'd15;

   // Random part: short frames, then one frame split by a mode change that
   // runs across the end of source line 0
   localparam int SHORT_FRAMES = 6;
   localparam int SPLIT_PIXELS = 180;

   typedef enum logic {ROW_PIXEL, ROW_CSR} row_kind_type;

   typedef struct packed {
      logic [3:0] idx;
      logic [7:0] val;
   } reg_write_type;

   typedef struct packed {
      row_kind_type  kind;
      req_type       px;
      logic [11:0]   reps;
      logic          typed;
      rsp_type       want;
      reg_write_type reg_wr;
   } stim_row_type;

   localparam req_type       IDLE_PX  = '0;
   localparam rsp_type       NO_RSP   = '0;
   localparam reg_write_type NO_WRITE = '0;

   // Directed rows, starting from reset: line 0 of a frame, 240-line mode, color
   localparam int DIR_ROWS = 18;
   localparam stim_row_type DIR_TABLE [DIR_ROWS] = '{
      // column 0, all samples at zero: chroma pulls red and blue under range
      '{ROW_PIXEL, '{8'd0, 8'd0, 8'd0, 1'b0}, 12'd1, 1'b1,
        '{8'd0, 8'd64, 8'd0, 6'd0, 6'd55, 1'b0}, NO_WRITE},
      '{ROW_PIXEL, '{8'd255, 8'd255, 8'd255, 1'b0}, 12'd5, 1'b0, NO_RSP, NO_WRITE},
      // column 6, all samples at full scale: red and blue saturate
      '{ROW_PIXEL, '{8'd255, 8'd255, 8'd255, 1'b0}, 12'd1, 1'b1,
        '{8'd255, 8'd192, 8'd255, 6'd1, 6'd55, 1'b0}, NO_WRITE},
      '{ROW_PIXEL, '{8'd0, 8'd0, 8'd0, 1'b0}, 12'd4, 1'b0, NO_RSP, NO_WRITE},
      // column 11, neutral chroma
      '{ROW_PIXEL, '{8'd128, 8'd128, 8'd128, 1'b0}, 12'd1, 1'b1,
        '{8'd128, 8'd128, 8'd128, 6'd2, 6'd55, 1'b0}, NO_WRITE},
      '{ROW_PIXEL, '{8'd17, 8'd200, 8'd3, 1'b0}, 12'd5, 1'b0, NO_RSP, NO_WRITE},
      // column 17, Cr' of -1 halves to zero, blue clamps low
      '{ROW_PIXEL, '{8'd100, 8'd1, 8'd127, 1'b0}, 12'd1, 1'b1,
        '{8'd99, 8'd100, 8'd0, 6'd3, 6'd55, 1'b0}, NO_WRITE},
      '{ROW_PIXEL, '{8'd1, 8'd254, 8'd129, 1'b0}, 12'd4, 1'b0, NO_RSP, NO_WRITE},
      // column 22 opens the second group; green saturates
      '{ROW_PIXEL, '{8'd255, 8'd0, 8'd0, 1'b0}, 12'd1, 1'b1,
        '{8'd127, 8'd255, 8'd127, 6'd4, 6'd55, 1'b0}, NO_WRITE},
      '{ROW_CSR, IDLE_PX, 12'd0, 1'b0, NO_RSP, '{CSR_GRAY_MODE, 8'h01}},
      '{ROW_PIXEL, '{8'd90, 8'd90, 8'd90, 1'b0}, 12'd5, 1'b0, NO_RSP, NO_WRITE},
      // column 28 in gray mode
      '{ROW_PIXEL, '{8'd37, 8'd0, 8'd255, 1'b0}, 12'd1, 1'b1,
        '{8'd37, 8'd37, 8'd37, 6'd5, 6'd55, 1'b0}, NO_WRITE},
      // frame restart mid-line
      '{ROW_PIXEL, '{8'd200, 8'd10, 8'd250, 1'b1}, 12'd1, 1'b1,
        '{8'd200, 8'd200, 8'd200, 6'd0, 6'd55, 1'b0}, NO_WRITE},
      '{ROW_CSR, IDLE_PX, 12'd0, 1'b0, NO_RSP, '{CSR_SPARE_LO, 8'hFF}},
      '{ROW_CSR, IDLE_PX, 12'd0, 1'b0, NO_RSP, '{CSR_SPARE_HI, 8'hFE}},
      '{ROW_CSR, IDLE_PX, 12'd0, 1'b0, NO_RSP, '{CSR_GRAY_MODE, 8'hFE}},
      '{ROW_CSR, IDLE_PX, 12'd0, 1'b0, NO_RSP, '{CSR_MODE_TALL, 8'hFF}},
      // rest of line 0, checked by the predictor
      '{ROW_PIXEL, '{8'd5, 8'd250, 8'd6, 1'b0}, 12'd351, 1'b0, NO_RSP, NO_WRITE}
   };

   // DUT ports
   logic       clock     = 1'b0;
   logic       reset     = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   req_type    req_data  = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b1;
   rsp_type    rsp_data;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [3:0] csr_index = '0;
   logic [7:0] csr_wdata = '0;

   // Predictor state and configuration
   logic       cfg_tall       = 1'b0;
   logic       cfg_gray       = 1'b0;
   logic [8:0] src_col        = '0;
   logic [8:0] src_line       = '0;
   logic [8:0] next_pick_line = '0;
   logic [2:0] step_phase     = '0;
   logic [5:0] rows_done      = '0;
   logic [4:0] group_pos      = '0;

   rsp_type pending_thumb_px [$];
   int      mismatch_count = 0;
   int      result_count   = 0;

   // Sender burst control
   bit          sender_steady = 1'b0;
   int unsigned burst_left    = 0;
   int unsigned gap_left      = 0;

   // Receiver stall pattern, redrawn each time the stall position wraps
   logic [31:0] stall_pattern = '1;
   logic [4:0]  stall_pos     = '0;

   video_thumbnail_decimator_yuv_rgb u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #HALF_PERIOD clock = ~clock;

   function automatic logic [7:0] saturate_byte(input int v);
      if (v > 255) return 8'd255;
      if (v < 0) return 8'd0;
      return 8'(v);
   endfunction

   // Steps the thumbnail predictor by one source pixel; returns 1 when a
   // thumbnail pixel is due, with its value in px_out
   function automatic bit predict_thumb_pixel(input req_type px, output rsp_type px_out);
      int         y, cb, cr;
      bit         on_row, hit;
      logic [1:0] slot;
      logic [5:0] col;
      logic [2:0] step;
      y  = px.luma;
      cb = int'(px.chroma_blue) - CHROMA_ZERO;
      cr = int'(px.chroma_red) - CHROMA_ZERO;
      px_out = '0;
      hit = 1'b0;
      if (px.frame_start) begin
         src_col        = '0;
         src_line       = '0;
         next_pick_line = '0;
         step_phase     = '0;
         rows_done      = '0;
         group_pos      = '0;
      end
      on_row = (rows_done < THUMB_HEIGHT) && (src_line == next_pick_line);
      // four picked columns per 22-column group
      case (group_pos)
         5'd0:    begin hit = 1'b1; slot = 2'd0; end
         5'd6:    begin hit = 1'b1; slot = 2'd1; end
         5'd11:   begin hit = 1'b1; slot = 2'd2; end
         5'd17:   begin hit = 1'b1; slot = 2'd3; end
         default: begin hit = 1'b0; slot = 2'd0; end
      endcase
      if (on_row && hit) begin
         col = 6'((src_col / GROUP_SPAN) * 4 + slot);
         if (cfg_gray) begin
            px_out.red   = px.luma;
            px_out.green = px.luma;
            px_out.blue  = px.luma;
         end else begin
            px_out.red   = saturate_byte(y + cr);
            px_out.green = saturate_byte(y - cr / 2);
            px_out.blue  = saturate_byte(y + cb);
         end
         px_out.thumb_col  = col;
         px_out.thumb_row  = 6'(THUMB_HEIGHT - 1 - rows_done);
         px_out.thumb_last = (rows_done == THUMB_HEIGHT - 1) && (col == LAST_COL);
      end
      // advance the raster counters
      src_col   = src_col + 1'b1;
      group_pos = (group_pos == GROUP_SPAN - 1) ? '0 : group_pos + 1'b1;
      if (src_col >= LINE_PIXELS) begin
         src_col   = '0;
         group_pos = '0;
         if (on_row) begin
            if (cfg_tall) step = (step_phase >= 3'd6) ? 3'd6 : 3'd5;
            else          step = (step_phase < 3'd2) ? 3'd5 : 3'd4;
            next_pick_line = next_pick_line + step;
            rows_done      = rows_done + 1'b1;
            step_phase     = (step_phase == CYCLE_ROWS - 1) ? '0 : step_phase + 1'b1;
         end
         src_line = src_line + 1'b1;
      end
      return on_row && hit;
   endfunction

   function automatic logic [7:0] rand_sample();
      if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      return 8'($urandom);
   endfunction

   task automatic report_mismatch(input string msg);
      if (mismatch_count < MAX_REPORTS) $display("MISMATCH at %0t ns: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic compare_field(input string name, input logic [7:0] got,
                                input logic [7:0] exp_val);
      if (got !== exp_val) begin
         report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                   result_count, name, got, exp_val));
      end
   endtask

   // One source pixel transaction; bursts and gaps come from the sender state
   task automatic send_pixel(input req_type px, input bit typed, input rsp_type typed_want);
      rsp_type want;
      bit      emits;
      if (gap_left > 0) begin
         req_valid <= 1'b0;
         while (gap_left > 0) begin
            @(posedge clock);
            gap_left--;
         end
      end
      req_valid <= 1'b1;
      req_data  <= px;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      emits = predict_thumb_pixel(px, want);
      if (emits) pending_thumb_px.push_back(typed ? typed_want : want);
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 32);
         gap_left   = sender_steady ? 0 : $urandom_range(1, 4);
      end
   endtask

   task automatic write_reg(input logic [3:0] idx, input logic [7:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_MODE_TALL: cfg_tall = val[0];
         CSR_GRAY_MODE: cfg_gray = val[0];
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // All thumbnail pixels delivered, then let unpicked pixels flush out
   task automatic wait_pipeline_idle();
      req_valid <= 1'b0;
      while (pending_thumb_px.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Random-content source pixels; noisy streams get stray frame restarts
   task automatic send_frame(input int unsigned count, input bit with_start, input bit noisy);
      req_type px;
      for (int unsigned k = 0; k < count; k++) begin
         px.luma        = rand_sample();
         px.chroma_blue = rand_sample();
         px.chroma_red  = rand_sample();
         px.frame_start = (k == 0 && with_start) || (noisy && $urandom_range(0, 599) == 0);
         send_pixel(px, 1'b0, NO_RSP);
      end
   endtask

   // Receiver stalls
   always @(posedge clock) begin : rsp_stall
      int unsigned style;
      if (stall_pos == '1) begin
         style = $urandom_range(0, 3);
         if (style == 0)      stall_pattern <= '1;
         else if (style == 1) stall_pattern <= $urandom;
         else                 stall_pattern <= $urandom | $urandom;
      end
      stall_pos <= stall_pos + 1'b1;
      rsp_ready <= stall_pattern[stall_pos];
   end

   // Thumbnail pixel checker
   always @(posedge clock) begin : check_thumb
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         result_count++;
         if (pending_thumb_px.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with no pixel pending",
                                      result_count));
         end else begin
            want = pending_thumb_px.pop_front();
            compare_field("red", rsp_data.red, want.red);
            compare_field("green", rsp_data.green, want.green);
            compare_field("blue", rsp_data.blue, want.blue);
            compare_field("thumb_col", 8'(rsp_data.thumb_col), 8'(want.thumb_col));
            compare_field("thumb_row", 8'(rsp_data.thumb_row), 8'(want.thumb_row));
            compare_field("thumb_last", 8'(rsp_data.thumb_last), 8'(want.thumb_last));
         end
      end
   end

   initial begin : stimulus
      int unsigned len;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed rows
      for (int r = 0; r < DIR_ROWS; r++) begin
         if (DIR_TABLE[r].kind == ROW_CSR) begin
            wait_pipeline_idle();
            write_reg(DIR_TABLE[r].reg_wr.idx, DIR_TABLE[r].reg_wr.val);
         end else begin
            for (int n = 0; n < DIR_TABLE[r].reps; n++) begin
               send_pixel(DIR_TABLE[r].px, DIR_TABLE[r].typed, DIR_TABLE[r].want);
            end
         end
      end

      // Short frames; the first four walk every mode and gray combination
      for (int unsigned ph = 0; ph < SHORT_FRAMES; ph++) begin
         wait_pipeline_idle();
         write_reg(CSR_MODE_TALL, {7'($urandom), (ph < 4) ? ph[0] : 1'($urandom)});
         write_reg(CSR_GRAY_MODE, {7'($urandom), (ph < 4) ? ph[1] : 1'($urandom)});
         if ($urandom_range(0, 1)) begin
            write_reg(4'($urandom_range(CSR_SPARE_HI, CSR_SPARE_LO)), 8'($urandom));
         end
         sender_steady = ($urandom_range(0, 3) == 0);
         len = $urandom_range(4, 40);
         send_frame(len, 1'b1, 1'b1);
      end

      // 288-line gray start, then switched to 240-line color mid-line
      wait_pipeline_idle();
      write_reg(CSR_MODE_TALL, 8'h01);
      write_reg(CSR_GRAY_MODE, 8'hFF);
      sender_steady = 1'b1;
      send_frame(SPLIT_PIXELS, 1'b1, 1'b0);
      wait_pipeline_idle();
      write_reg(CSR_MODE_TALL, 8'h80);
      write_reg(CSR_GRAY_MODE, 8'h7E);
      sender_steady = 1'b0;
      send_frame(SPLIT_PIXELS, 1'b0, 1'b0);

      wait_pipeline_idle();
      if (mismatch_count == 0) begin
         $display("video_thumbnail_decimator_yuv_rgb test passed");
      end else begin
         $display("video_thumbnail_decimator_yuv_rgb test failed");
      end
      $finish;
   end

   // Watchdog
   initial begin : watchdog
      #TIMEOUT_NS;
      $display("video_thumbnail_decimator_yuv_rgb test failed");
      $finish;
   end

endmodule
